// ===== hdl/zvdd_pkg.sv =====
// Shared constants and types for the zigzag varint delta decoder.
`timescale 1ns / 1ps

package zvdd_pkg;

  localparam int MAX_METRICS      = 4096;
  localparam int MAX_SAMPLES      = 1024;
  localparam int MAX_VARINT_BYTES = 10;

  localparam int CMD_W     = 2;
  localparam int MCOUNT_W  = 13;
  localparam int METRIC_W  = 12;
  localparam int SAMPLE_W  = 11;
  localparam int VALUE_W   = 64;
  localparam int BYTE_W    = 8;
  localparam int VCOUNT_W  = 4;
  localparam int EPOCH_W   = 8;
  localparam int ENTRY_W   = EPOCH_W + VALUE_W;

  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd2;

  localparam int CONT_BIT = 7;
  localparam int DIGIT_W  = 7;

  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef enum logic [1:0] {
    KIND_VALUE    = 2'd0,
    KIND_RUN      = 2'd1,
    KIND_OVERLONG = 2'd2,
    KIND_TRUNC    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_RUN   = 4'b0010,
    PH_DELTA = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

endpackage

// ===== hdl/zigzag_varint_delta_decoder_top.sv =====
// Zigzag varint delta decoder: chunk setup, reference table and per-byte decode.
// A word accepted into the input register is decoded there; its result is registered on the outputs.
// Throughput: one word per cycle; a held result stalls the input in the same cycle.
// Reference table: 4096 x 72 RAM with per-chunk epoch tags; loaded flags age out by epoch.
// Reset: sync, active high; then a sweep over all 4096 entries clears the epoch tags (req_stall high).
// The same sweep follows every chunk start that wraps the 8-bit epoch.
`timescale 1ns / 1ps

module zigzag_varint_delta_decoder_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic [zvdd_pkg::CMD_W-1:0]            cmd,
  input  logic [zvdd_pkg::MCOUNT_W-1:0]         metric_count,
  input  logic [zvdd_pkg::SAMPLE_W-1:0]         sample_count,
  input  logic [zvdd_pkg::METRIC_W-1:0]         ref_index,
  input  logic signed [zvdd_pkg::VALUE_W-1:0]   ref_value,
  input  logic [zvdd_pkg::BYTE_W-1:0]           data_byte,
  input  logic                                  last_byte,
  output logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  output logic [1:0]                            kind,
  output logic [zvdd_pkg::METRIC_W-1:0]         metric_index,
  output logic [zvdd_pkg::SAMPLE_W-1:0]         sample_index,
  output logic signed [zvdd_pkg::VALUE_W-1:0]   value,
  output logic [zvdd_pkg::SAMPLE_W-1:0]         run_length,
  output logic                                  column_last,
  output logic                                  chunk_last
);
  import zvdd_pkg::*;

  // input register
  logic                  word_valid;
  logic [CMD_W-1:0]      word_cmd;
  logic [MCOUNT_W-1:0]   word_metrics;
  logic [SAMPLE_W-1:0]   word_samples;
  logic [METRIC_W-1:0]   word_index;
  logic [VALUE_W-1:0]    word_ref;
  logic [BYTE_W-1:0]     word_byte;
  logic                  word_last;

  // decoder state
  phase_t                phase, phase_next;
  logic [MCOUNT_W-1:0]   chunk_metrics, chunk_metrics_next;
  logic [SAMPLE_W-1:0]   chunk_samples, chunk_samples_next;
  logic [METRIC_W-1:0]   current_metric, current_metric_next;
  logic [SAMPLE_W-1:0]   current_row, current_row_next;
  logic [VALUE_W-1:0]    acc, acc_next;
  logic [VCOUNT_W-1:0]   varint_count, varint_count_next;
  logic [VALUE_W-1:0]    running, running_next;
  logic [EPOCH_W-1:0]    epoch, epoch_next;

  // clearing sweep
  logic                  clearing;
  logic                  clear_start;
  logic [METRIC_W-1:0]   clear_addr;

  // reference memory
  logic [ENTRY_W-1:0]    ref_mem [MAX_METRICS];
  logic [ENTRY_W-1:0]    rd_entry;
  logic                  mem_we;
  logic [METRIC_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic                  load_we;

  // handshake
  logic                  out_ready;
  logic                  fire;
  logic                  accept;

  // result of current word
  logic                  res_has;
  kind_t                 res_kind;
  logic [SAMPLE_W-1:0]   res_row;
  logic [VALUE_W-1:0]    res_value;
  logic [SAMPLE_W-1:0]   res_run;
  logic                  res_col_last;
  logic                  res_chunk_last;

  assign out_ready = !rsp_valid || !rsp_stall;
  assign fire      = word_valid && !clearing && out_ready;
  assign req_stall = clearing || (word_valid && !fire);
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (accept) begin
      word_valid <= 1'b1;
    end else if (fire) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_cmd     <= cmd;
      word_metrics <= metric_count;
      word_samples <= sample_count;
      word_index   <= ref_index;
      word_ref     <= $unsigned(ref_value);
      word_byte    <= data_byte;
      word_last    <= last_byte;
    end
  end

  always_comb begin
    logic [VALUE_W-1:0]  acc_or;
    logic [6:0]          shamt;
    logic [VCOUNT_W-1:0] count_inc;
    logic [VALUE_W-1:0]  delta;
    logic [VALUE_W-1:0]  sum;
    logic [VALUE_W-1:0]  refv;
    logic [SAMPLE_W-1:0] run_cnt;
    logic [SAMPLE_W-1:0] row_inc;
    logic [SAMPLE_W-1:0] err_row;
    logic [MCOUNT_W-1:0] metric_inc;
    logic                col_last;
    logic                is_run;

    phase_next          = phase;
    chunk_metrics_next  = chunk_metrics;
    chunk_samples_next  = chunk_samples;
    current_metric_next = current_metric;
    current_row_next    = current_row;
    acc_next            = acc;
    varint_count_next   = varint_count;
    running_next        = running;
    epoch_next          = epoch;
    clear_start         = 1'b0;
    load_we             = 1'b0;
    res_has             = 1'b0;
    res_kind            = KIND_VALUE;
    res_row             = '0;
    res_value           = '0;
    res_run             = '0;
    res_col_last        = 1'b0;
    res_chunk_last      = 1'b0;

    shamt      = 7'(varint_count) * 7'(DIGIT_W);
    acc_or     = acc;
    if (varint_count < VCOUNT_W'(MAX_VARINT_BYTES)) begin
      acc_or = acc | (VALUE_W'(word_byte[DIGIT_W-1:0]) << shamt[5:0]);
    end
    count_inc  = varint_count + VCOUNT_W'(1);
    delta      = (acc_or >> 1) ^ {VALUE_W{acc_or[0]}};
    sum        = running + delta;
    refv       = (rd_entry[ENTRY_W-1:VALUE_W] == epoch) ? rd_entry[VALUE_W-1:0] : '0;
    run_cnt    = (acc_or > VALUE_W'(chunk_samples)) ? chunk_samples : acc_or[SAMPLE_W-1:0];
    row_inc    = current_row + SAMPLE_W'(1);
    is_run     = (phase == PH_RUN);
    err_row    = is_run ? SAMPLE_W'(1) : row_inc;
    metric_inc = {1'b0, current_metric} + MCOUNT_W'(1);
    col_last   = is_run ? (run_cnt >= chunk_samples) : (row_inc >= chunk_samples);

    if (fire) begin
      unique case (word_cmd)
        CMD_BEGIN: begin
          chunk_metrics_next  = (word_metrics > MCOUNT_W'(MAX_METRICS)) ?
                                MCOUNT_W'(MAX_METRICS) : word_metrics;
          chunk_samples_next  = (word_samples > SAMPLE_W'(MAX_SAMPLES)) ?
                                SAMPLE_W'(MAX_SAMPLES) : word_samples;
          current_metric_next = '0;
          current_row_next    = '0;
          acc_next            = '0;
          varint_count_next   = '0;
          running_next        = '0;
          phase_next = (word_metrics == '0 || word_samples == '0) ? PH_DONE : PH_RUN;
          // new epoch retires all loaded flags; wrap forces a tag sweep
          if (epoch == EPOCH_LAST) begin
            epoch_next  = EPOCH_FIRST;
            clear_start = 1'b1;
          end else begin
            epoch_next = epoch + EPOCH_W'(1);
          end
        end
        CMD_LOAD: begin
          load_we = ({1'b0, word_index} < MCOUNT_W'(MAX_METRICS));
        end
        CMD_BYTE: begin
          if (phase == PH_RUN || phase == PH_DELTA) begin
            acc_next          = acc_or;
            varint_count_next = count_inc;
            if (word_byte[CONT_BIT]) begin
              if (count_inc >= VCOUNT_W'(MAX_VARINT_BYTES) || word_last) begin
                res_has        = 1'b1;
                res_kind       = (count_inc >= VCOUNT_W'(MAX_VARINT_BYTES)) ?
                                 KIND_OVERLONG : KIND_TRUNC;
                res_row        = err_row;
                res_chunk_last = 1'b1;
                phase_next     = PH_DONE;
              end
            end else begin
              acc_next          = '0;
              varint_count_next = '0;
              res_has           = 1'b1;
              res_col_last      = col_last;
              if (is_run) begin
                running_next     = refv;
                current_row_next = run_cnt;
                res_kind         = KIND_RUN;
                res_row          = SAMPLE_W'(1);
                res_value        = refv;
                res_run          = run_cnt;
              end else begin
                running_next     = sum;
                current_row_next = row_inc;
                res_kind         = KIND_VALUE;
                res_row          = row_inc;
                res_value        = sum;
                res_run          = SAMPLE_W'(1);
              end
              if (col_last) begin
                current_metric_next = metric_inc[METRIC_W-1:0];
                current_row_next    = '0;
                if (metric_inc >= chunk_metrics) begin
                  phase_next     = PH_DONE;
                  res_chunk_last = 1'b1;
                end else begin
                  phase_next = PH_RUN;
                end
              end else begin
                phase_next = PH_DELTA;
              end
              if (word_last) begin
                phase_next     = PH_DONE;
                res_chunk_last = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      chunk_metrics  <= '0;
      chunk_samples  <= '0;
      current_metric <= '0;
      current_row    <= '0;
      acc            <= '0;
      varint_count   <= '0;
      running        <= '0;
      epoch          <= EPOCH_FIRST;
    end else begin
      phase          <= phase_next;
      chunk_metrics  <= chunk_metrics_next;
      chunk_samples  <= chunk_samples_next;
      current_metric <= current_metric_next;
      current_row    <= current_row_next;
      acc            <= acc_next;
      varint_count   <= varint_count_next;
      running        <= running_next;
      epoch          <= epoch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clear_start) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + METRIC_W'(1);
      if (clear_addr == METRIC_W'(MAX_METRICS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign mem_we    = clearing || load_we;
  assign mem_waddr = clearing ? clear_addr : word_index;
  assign mem_wdata = clearing ? {EPOCH_NONE, {VALUE_W{1'b0}}} : {epoch, word_ref};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ref_mem[mem_waddr] <= mem_wdata;
    end
  end

  // read tracks the metric the next word will see; bypass covers a same-cycle write
  always_ff @(posedge clk) begin
    if (mem_we && mem_waddr == current_metric_next) begin
      rd_entry <= mem_wdata;
    end else begin
      rd_entry <= ref_mem[current_metric_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire && res_has) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_has) begin
      kind         <= res_kind;
      metric_index <= current_metric;
      sample_index <= res_row;
      value        <= $signed(res_value);
      run_length   <= res_run;
      column_last  <= res_col_last;
      chunk_last   <= res_chunk_last;
    end
  end

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    clearing |-> req_stall)
    else $error("input taken during tag sweep");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_RUN || phase == PH_DELTA) |-> varint_count < VCOUNT_W'(MAX_VARINT_BYTES))
    else $error("varint byte count out of range");

  a_error_stops: assert property (@(posedge clk) disable iff (rst)
    fire && res_has && (res_kind == KIND_OVERLONG || res_kind == KIND_TRUNC)
    |=> phase == PH_DONE)
    else $error("decode continued after varint error");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DELTA |-> current_row < chunk_samples)
    else $error("row passed sample count");

endmodule

// ===== tb/zigzag_varint_delta_decoder_top_tb.sv =====
// Self-checking testbench for the zigzag varint delta decoder top level.
`timescale 1ns / 1ps

module zigzag_varint_delta_decoder_top_tb;
  import zvdd_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam int ITEMS       = 1800;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_GAP     = 16;

  typedef struct packed {
    kind_t               kind;
    logic [METRIC_W-1:0] metric;
    logic [SAMPLE_W-1:0] sample;
    logic [VALUE_W-1:0]  val;
    logic [SAMPLE_W-1:0] run;
    logic                col_last;
    logic                chunk_last;
  } sample_rec_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       req_valid;
  logic                       req_stall;
  logic [CMD_W-1:0]           cmd;
  logic [MCOUNT_W-1:0]        metric_count;
  logic [SAMPLE_W-1:0]        sample_count;
  logic [METRIC_W-1:0]        ref_index;
  logic signed [VALUE_W-1:0]  ref_value;
  logic [BYTE_W-1:0]          data_byte;
  logic                       last_byte;
  logic                       rsp_valid;
  logic                       rsp_stall;
  logic [1:0]                 kind;
  logic [METRIC_W-1:0]        metric_index;
  logic [SAMPLE_W-1:0]        sample_index;
  logic signed [VALUE_W-1:0]  value;
  logic [SAMPLE_W-1:0]        run_length;
  logic                       column_last;
  logic                       chunk_last;

  zigzag_varint_delta_decoder_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder shadow state
  logic [VALUE_W-1:0] ref_mem [MAX_METRICS];
  bit                 ref_seen [MAX_METRICS];
  int unsigned        dec_metrics = 0;
  int unsigned        dec_samples = 0;
  int unsigned        dec_metric = 0;
  int unsigned        dec_row = 0;
  int unsigned        dec_nbytes = 0;
  phase_t             dec_phase = PH_IDLE;
  logic [VALUE_W-1:0] dec_acc = '0;
  logic [VALUE_W-1:0] dec_running = '0;

  sample_rec_t        decoded_q[$];
  logic [BYTE_W-1:0]  byte_q[$];
  int                 mismatches = 0;
  int                 words_sent = 0;
  bit                 req_quiet = 1'b0;
  bit                 rsp_quiet = 1'b0;
  bit                 rsp_hold_req = 1'b0;

  function automatic void decode_word(logic [CMD_W-1:0] c, logic [MCOUNT_W-1:0] mc,
                                      logic [SAMPLE_W-1:0] sc, logic [METRIC_W-1:0] ri,
                                      logic [VALUE_W-1:0] rv, logic [BYTE_W-1:0] db,
                                      logic lb);
    sample_rec_t        r;
    logic [VALUE_W-1:0] word;
    int unsigned        err_row;
    case (c)
      CMD_BEGIN: begin
        dec_metrics = (32'(mc) > MAX_METRICS) ? MAX_METRICS : 32'(mc);
        dec_samples = (32'(sc) > MAX_SAMPLES) ? MAX_SAMPLES : 32'(sc);
        foreach (ref_seen[i]) ref_seen[i] = 1'b0;
        dec_metric = 0;
        dec_row = 0;
        dec_acc = '0;
        dec_nbytes = 0;
        dec_running = '0;
        dec_phase = (dec_metrics == 0 || dec_samples == 0) ? PH_DONE : PH_RUN;
      end
      CMD_LOAD: begin
        ref_mem[ri] = rv;
        ref_seen[ri] = 1'b1;
      end
      CMD_BYTE: begin
        if (dec_phase == PH_RUN || dec_phase == PH_DELTA) begin
          err_row = (dec_phase == PH_RUN) ? 1 : dec_row + 1;
          if (dec_nbytes < MAX_VARINT_BYTES)
            dec_acc |= VALUE_W'(db[DIGIT_W-1:0]) << (DIGIT_W * dec_nbytes);
          dec_nbytes++;
          r.metric = dec_metric[METRIC_W-1:0];
          if (db[CONT_BIT]) begin
            if (dec_nbytes >= MAX_VARINT_BYTES || lb) begin
              r.kind = (dec_nbytes >= MAX_VARINT_BYTES) ? KIND_OVERLONG : KIND_TRUNC;
              r.sample = err_row[SAMPLE_W-1:0];
              r.val = '0;
              r.run = '0;
              r.col_last = 1'b0;
              r.chunk_last = 1'b1;
              decoded_q = {decoded_q, r};
              dec_phase = PH_DONE;
            end
          end else begin
            word = dec_acc;
            dec_acc = '0;
            dec_nbytes = 0;
            if (dec_phase == PH_RUN) begin
              r.kind = KIND_RUN;
              r.sample = SAMPLE_W'(1);
              r.run = (word > VALUE_W'(dec_samples)) ? dec_samples[SAMPLE_W-1:0]
                                                     : word[SAMPLE_W-1:0];
              r.val = ref_seen[dec_metric] ? ref_mem[dec_metric] : '0;
              dec_running = r.val;
              dec_row = 32'(r.run);
            end else begin
              dec_running += (word >> 1) ^ {VALUE_W{word[0]}};
              dec_row++;
              r.kind = KIND_VALUE;
              r.sample = dec_row[SAMPLE_W-1:0];
              r.val = dec_running;
              r.run = SAMPLE_W'(1);
            end
            r.col_last = (dec_row >= dec_samples);
            r.chunk_last = 1'b0;
            if (r.col_last) begin
              dec_metric++;
              dec_row = 0;
              if (dec_metric >= dec_metrics) begin
                dec_phase = PH_DONE;
                r.chunk_last = 1'b1;
              end else begin
                dec_phase = PH_RUN;
              end
            end else begin
              dec_phase = PH_DELTA;
            end
            if (lb && dec_phase != PH_DONE) begin
              dec_phase = PH_DONE;
              r.chunk_last = 1'b1;
            end
            decoded_q = {decoded_q, r};
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] zigzag(logic [VALUE_W-1:0] d);
    return (d << 1) ^ {VALUE_W{d[VALUE_W-1]}};
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return VALUE_W'($urandom_range(0, 255)) - VALUE_W'(128);
      3: return {{32{r[31]}}, r};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // appends one varint, now and then in a redundant longer form
  function automatic void encode_varint(logic [VALUE_W-1:0] v);
    logic [BYTE_W-1:0] b;
    int                n;
    n = 0;
    do begin
      b = {1'b0, v[DIGIT_W-1:0]};
      v = v >> DIGIT_W;
      if (v != 0) b[CONT_BIT] = 1'b1;
      byte_q = {byte_q, b};
      n++;
    end while (v != 0);
    if ($urandom_range(0, 9) == 0 && n < MAX_VARINT_BYTES) begin
      byte_q[byte_q.size() - 1][CONT_BIT] = 1'b1;
      byte_q = {byte_q, BYTE_W'(0)};
    end
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] c, input logic [MCOUNT_W-1:0] mc,
                           input logic [SAMPLE_W-1:0] sc, input logic [METRIC_W-1:0] ri,
                           input logic [VALUE_W-1:0] rv, input logic [BYTE_W-1:0] db,
                           input logic lb);
    int unsigned gap;
    gap = req_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= c;
    metric_count <= mc;
    sample_count <= sc;
    ref_index <= ri;
    ref_value <= rv;
    data_byte <= db;
    last_byte <= lb;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    decode_word(c, mc, sc, ri, rv, db, lb);
    words_sent++;
  endtask

  task automatic begin_chunk(input int unsigned m, input int unsigned s);
    send_word(CMD_BEGIN, m[MCOUNT_W-1:0], s[SAMPLE_W-1:0], METRIC_W'($urandom),
              {$urandom, $urandom}, BYTE_W'($urandom), 1'($urandom));
  endtask

  task automatic load_ref(input logic [METRIC_W-1:0] i, input logic [VALUE_W-1:0] v);
    send_word(CMD_LOAD, MCOUNT_W'($urandom), SAMPLE_W'($urandom), i, v,
              BYTE_W'($urandom), 1'($urandom));
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lb);
    send_word(CMD_BYTE, MCOUNT_W'($urandom), SAMPLE_W'($urandom), METRIC_W'($urandom),
              {$urandom, $urandom}, b, lb);
  endtask

  task automatic noise_word();
    send_word(CMD_NONE, MCOUNT_W'($urandom), SAMPLE_W'($urandom), METRIC_W'($urandom),
              {$urandom, $urandom}, BYTE_W'($urandom), 1'($urandom));
  endtask

  task automatic flush_bytes(input bit last, input bit noisy);
    int k;
    for (k = 0; k < byte_q.size(); k++) begin
      if (noisy && $urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 1) noise_word();
        else load_ref(METRIC_W'($urandom_range(0, 4)), rand_value());
      end
      send_byte(byte_q[k], last && (k == byte_q.size() - 1));
    end
    byte_q.delete();
  endtask

  task automatic wait_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0);
  endtask

  task automatic test_ignored_words();
    send_byte(8'hFF, 1'b1);
    noise_word();
    begin_chunk(0, 5);
    send_byte(8'h01, 1'b0);
    begin_chunk(3, 0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_column_decode();
    begin_chunk(2, 3);
    load_ref(0, 64'h8000_0000_0000_0000);
    load_ref(1, 64'h7FFF_FFFF_FFFF_FFFF);
    encode_varint('0);
    encode_varint(zigzag(-64'sd1));
    encode_varint(zigzag(64'sd63));
    encode_varint(zigzag(-64'sd64));
    encode_varint(64'd200);
    flush_bytes(1'b1, 1'b0);
  endtask

  task automatic test_saturated_counts();
    begin_chunk(8191, 2047);
    load_ref(12'hFFF, rand_value());
    send_byte(8'h00, 1'b0);
    send_byte(8'h05, 1'b1);
  endtask

  task automatic test_varint_errors();
    begin_chunk(1, 4);
    send_byte(8'h80, 1'b1);
    begin_chunk(1, 4);
    repeat (MAX_VARINT_BYTES) send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_backpressure();
    int k;
    req_quiet = 1'b1;
    rsp_hold_req = 1'b1;
    begin_chunk(2, 20);
    load_ref(0, rand_value());
    for (k = 0; k < 42; k++) encode_varint((k % 21 == 0) ? '0 : zigzag(rand_value()));
    flush_bytes(1'b0, 1'b0);
    req_quiet = 1'b0;
    wait_drain();
  endtask

  task automatic test_epoch_wrap();
    int k;
    for (k = 0; k < 270; k++) begin
      begin_chunk(1, 1);
      if (k % 2 == 0) load_ref(0, rand_value());
      send_byte(BYTE_W'($urandom_range(0, 127)), 1'($urandom));
    end
  endtask

  task automatic random_chunk();
    int unsigned m, s, m_eff, s_eff, cols, rows, run_eff, c, k, p, pick;
    logic [VALUE_W-1:0] run;
    bit last;
    pick = $urandom_range(0, 99);
    if (pick < 2) m = 0;
    else if (pick < 6) m = $urandom_range(MAX_METRICS + 1, 8191);
    else if (pick < 10) m = $urandom_range(5, MAX_METRICS);
    else m = $urandom_range(1, 4);
    pick = $urandom_range(0, 99);
    if (pick < 2) s = 0;
    else if (pick < 6) s = $urandom_range(MAX_SAMPLES + 1, 2047);
    else if (pick < 10) s = $urandom_range(7, MAX_SAMPLES);
    else s = $urandom_range(1, 6);
    m_eff = (m > MAX_METRICS) ? MAX_METRICS : m;
    s_eff = (s > MAX_SAMPLES) ? MAX_SAMPLES : s;
    cols = (m_eff > 5) ? 5 : m_eff;
    last = (m_eff > 5) ? 1'b1 : 1'($urandom);
    begin_chunk(m, s);
    for (c = 0; c < cols; c++)
      if ($urandom_range(0, 9) < 7) load_ref(METRIC_W'(c), rand_value());
    if ($urandom_range(0, 9) == 0) load_ref(METRIC_W'($urandom_range(0, 4095)), rand_value());
    for (c = 0; c < cols; c++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) run = '0;
      else if (pick < 70) run = VALUE_W'($urandom_range(1, s_eff));
      else if (pick < 85) run = VALUE_W'(s_eff + $urandom_range(0, 3));
      else run = {$urandom, $urandom};
      encode_varint(run);
      run_eff = (run > VALUE_W'(s_eff)) ? s_eff : 32'(run);
      rows = s_eff - run_eff;
      if (rows > 8) begin
        rows = 8;
        last = 1'b1;
      end
      for (k = 0; k < rows; k++) encode_varint(zigzag(rand_value()));
    end
    pick = $urandom_range(0, 99);
    p = $urandom_range(0, byte_q.size());
    if (pick < 12) begin
      while (byte_q.size() > p) void'(byte_q.pop_back());
      byte_q = {byte_q, BYTE_W'(8'h80 | $urandom_range(0, 127))};
      last = 1'b1;
    end else if (pick < 22) begin
      for (k = 0; k < MAX_VARINT_BYTES; k++)
        byte_q.insert(p, BYTE_W'(8'h80 | $urandom_range(0, 127)));
    end
    flush_bytes(last, 1'b1);
    if ($urandom_range(0, 4) == 0) begin
      send_byte(BYTE_W'($urandom), 1'($urandom));
      noise_word();
    end
  endtask

  task automatic test_random_stream();
    while (words_sent < ITEMS) begin
      req_quiet = ($urandom_range(0, 9) == 0);
      rsp_quiet = ($urandom_range(0, 9) == 0);
      random_chunk();
    end
    req_quiet = 1'b0;
    rsp_quiet = 1'b0;
  endtask

  function automatic void report(string what, sample_rec_t want, sample_rec_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: want kind=%0d metric=%0d row=%0d value=%h run=%0d col=%0b chunk=%0b",
               $time, what, want.kind, want.metric, want.sample, want.val, want.run,
               want.col_last, want.chunk_last);
      $display("%0t %s: got  kind=%0d metric=%0d row=%0d value=%h run=%0d col=%0b chunk=%0b",
               $time, what, got.kind, got.metric, got.sample, got.val, got.run,
               got.col_last, got.chunk_last);
    end
  endfunction

  always @(posedge clk) begin
    sample_rec_t got;
    sample_rec_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      got = '{kind_t'(kind), metric_index, sample_index, value, run_length,
              column_last, chunk_last};
      if (decoded_q.size() == 0) begin
        report("unexpected word", '0, got);
      end else begin
        want = decoded_q.pop_front();
        if (got.kind !== want.kind || got.metric !== want.metric ||
            got.sample !== want.sample || got.val !== want.val || got.run !== want.run ||
            got.col_last !== want.col_last || got.chunk_last !== want.chunk_last)
          report("mismatch", want, got);
      end
    end
  end

  initial begin : receiver
    int unsigned wait_left;
    int unsigned hold_left;
    wait_left = 0;
    hold_left = 0;
    rsp_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (rsp_valid && !rsp_stall) wait_left = rsp_quiet ? 0 : $urandom_range(0, MAX_GAP);
      else if (wait_left > 0) wait_left--;
      if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0) || (wait_left > 0);
    end
  end

  initial begin
    #(10_000_000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    cmd = CMD_BEGIN;
    metric_count = '0;
    sample_count = '0;
    ref_index = '0;
    ref_value = '0;
    data_byte = '0;
    last_byte = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_ignored_words();
    test_column_decode();
    test_saturated_counts();
    test_varint_errors();
    test_backpressure();
    test_epoch_wrap();
    test_random_stream();
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/zvdd_pkg.sv
hdl/zigzag_varint_delta_decoder_top.sv
tb/zigzag_varint_delta_decoder_top_tb.sv
